/* src/rqk_pkg.sv */
// Shared codes, state encoding and command struct for the ready queue.
package rqk_pkg;

	localparam int FUNC_W   = 2;
	localparam int IN_ID_W  = 8;
	localparam int OUT_ID_W = 8;
	localparam int STS_W    = 2;
	localparam int OCC_W    = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REM_HEAD = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REM_ID   = 2'd2;

	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY     = 2'd2;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} cmd_t;

endpackage

/* src/ready_queue_with_keyed_removal_top.sv */
// An accepted item goes through key search (ST_SEARCH), then commit (ST_COMMIT), to m_tvalid.
// Items are handled one at a time (accept, search, commit); commit also waits
// while the previous result still sits in the output register untaken.
// A finished item waits in the output register while the next item is accepted.
// Reset: asynchronous, active low; clears the entry count and handshake state.
// Slot contents are not cleared; no clearing pass, items accepted right after reset.
module ready_queue_with_keyed_removal_top #(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] func, [9:2] proc_id, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] result_id, [9:8] status, [14:10] occupancy, [15] zero
);
	import rqk_pkg::*;

	cmd_t                cmd;
	logic [OUT_ID_W-1:0] res_id;
	logic [STS_W-1:0]    res_status;
	logic [OCC_W-1:0]    res_occ;

	rqk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rqk_dp #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_func    (s_tdata[1:0]),
		.in_proc_id (s_tdata[9:2]),
		.res_id     (res_id),
		.res_status (res_status),
		.res_occ    (res_occ)
	);

	assign m_tdata = {1'b0, res_occ, res_status, res_id};

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item still in work");

	a_load_then_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.search)
		else $error("search step did not follow item load");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit did not present a result");

	a_commit_needs_space: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && m_tvalid) |-> m_tready)
		else $error("commit overwrote a result not yet taken");

endmodule

/* src/rqk_ctrl.sv */
// Sequencer for the ready queue: input handshake, search/commit steps, output valid.
module rqk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output rqk_pkg::cmd_t cmd
);
	import rqk_pkg::*;

	state_t state_q, state_nxt;
	logic   out_vld_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_vld_q;
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.search = (state_q == ST_SEARCH);
	// result register must be free (or draining this cycle) before commit
	assign cmd.commit = (state_q == ST_COMMIT) && (!out_vld_q || m_tready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_nxt = ST_SEARCH;
			end
			ST_SEARCH: begin
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (cmd.commit) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

endmodule

/* src/rqk_dp.sv */
// Queue datapath: slot registers, parallel key compare, gap-closing shift, result register.
module rqk_dp #(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rqk_pkg::cmd_t                   cmd,
	input  logic [rqk_pkg::FUNC_W-1:0]      in_func,
	input  logic [rqk_pkg::IN_ID_W-1:0]     in_proc_id,
	output logic [rqk_pkg::OUT_ID_W-1:0]    res_id,
	output logic [rqk_pkg::STS_W-1:0]       res_status,
	output logic [rqk_pkg::OCC_W-1:0]       res_occ
);
	import rqk_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [ID_WIDTH-1:0] slots_q [DEPTH];
	logic [CW-1:0]       count_q, count_nxt;
	logic [FUNC_W-1:0]   func_q;
	logic [ID_WIDTH-1:0] key_q, key_in;
	logic [DEPTH-1:0]    valid, match_d, match_q, lowest, shift_en;
	logic [ID_WIDTH-1:0] rid;
	logic [STS_W-1:0]    sts;
	logic                do_ins, do_rem, hit;
	logic [OUT_ID_W-1:0] rid_out;
	logic [OCC_W-1:0]    occ_out;

	// key bits beyond the port width are zero; port bits at and above ID_WIDTH are dropped
	always_comb begin
		key_in = '0;
		for (int b = 0; b < ID_WIDTH && b < IN_ID_W; b++) key_in[b] = in_proc_id[b];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			key_q  <= key_in;
		end
	end

	// step 1: remove-by-id compares every occupied slot against the key; remove-head marks slot 0
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i] = CW'(i) < count_q;
			if (func_q == FN_REM_HEAD) match_d[i] = (i == 0) && valid[i];
			else match_d[i] = (func_q == FN_REM_ID) && valid[i] && (slots_q[i] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) match_q <= match_d;
	end

	// oldest match and every younger slot move up one place
	assign lowest   = match_q & (~match_q + DEPTH'(1));
	assign shift_en = ~(lowest - DEPTH'(1));
	assign hit      = |match_q;

	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		rid    = '0;
		sts    = STS_OK;
		case (func_q)
			FN_INSERT: begin
				if (count_q == CW'(DEPTH)) begin
					sts = STS_FULL;
				end else begin
					do_ins = 1'b1;
					rid    = key_q;
				end
			end
			FN_REM_HEAD, FN_REM_ID: begin
				if (count_q == '0) begin
					sts = STS_EMPTY;
				end else if (hit) begin
					do_rem = 1'b1;
					rid    = (func_q == FN_REM_HEAD) ? slots_q[0] : key_q;
				end else begin
					sts = STS_NOT_FOUND;
				end
			end
			default: begin
				rid = '0;
			end
		endcase
		if (do_ins) count_nxt = count_q + CW'(1);
		else if (do_rem) count_nxt = count_q - CW'(1);
		else count_nxt = count_q;
	end

	always_comb begin
		rid_out = '0;
		for (int b = 0; b < ID_WIDTH && b < OUT_ID_W; b++) rid_out[b] = rid[b];
		occ_out = '0;
		for (int b = 0; b < CW && b < OCC_W; b++) occ_out[b] = count_nxt[b];
	end

	// step 2: apply the update
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (do_ins) slots_q[count_q[AW-1:0]] <= key_q;
			if (do_rem) begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (shift_en[i]) slots_q[i] <= slots_q[i+1];
				end
			end
			res_id     <= rid_out;
			res_status <= sts;
			res_occ    <= occ_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

endmodule
